// ===== design/tkse_pkg.sv =====
package tkse_pkg;

	localparam int KEY_W   = 5;
	localparam int BYTE_W  = 8;
	localparam int SEQ_MAX = 7;
	localparam int LEN_W   = 3;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;

	localparam key_t KEY_NONE   = 5'd0;
	localparam key_t KEY_ENTER  = 5'd1;
	localparam key_t KEY_BKSP   = 5'd2;
	localparam key_t KEY_TAB    = 5'd3;
	localparam key_t KEY_ESC    = 5'd4;
	localparam key_t KEY_UP     = 5'd5;
	localparam key_t KEY_DOWN   = 5'd6;
	localparam key_t KEY_RIGHT  = 5'd7;
	localparam key_t KEY_LEFT   = 5'd8;
	localparam key_t KEY_HOME   = 5'd9;
	localparam key_t KEY_END    = 5'd10;
	localparam key_t KEY_INS    = 5'd11;
	localparam key_t KEY_DEL    = 5'd12;
	localparam key_t KEY_PGUP   = 5'd13;
	localparam key_t KEY_PGDN   = 5'd14;
	localparam key_t KEY_F1     = 5'd15;
	localparam key_t KEY_F2     = 5'd16;
	localparam key_t KEY_F3     = 5'd17;
	localparam key_t KEY_F4     = 5'd18;
	localparam key_t KEY_F5     = 5'd19;
	localparam key_t KEY_F6     = 5'd20;
	localparam key_t KEY_F7     = 5'd21;
	localparam key_t KEY_F8     = 5'd22;
	localparam key_t KEY_F9     = 5'd23;
	localparam key_t KEY_F10    = 5'd24;
	localparam key_t KEY_F11    = 5'd25;
	localparam key_t KEY_F12    = 5'd26;

	localparam byte_t CH_ESC   = 8'h1b;
	localparam byte_t CH_CR    = 8'h0d;
	localparam byte_t CH_DEL   = 8'h7f;
	localparam byte_t CH_HT    = 8'h09;
	localparam byte_t CH_LBRK  = 8'h5b; // '['
	localparam byte_t CH_O     = 8'h4f;
	localparam byte_t CH_Z     = 8'h5a;
	localparam byte_t CH_SEMI  = 8'h3b;
	localparam byte_t CH_TILDE = 8'h7e;
	localparam byte_t CH_ONE   = 8'h31;
	localparam byte_t CH_P     = 8'h50;

	// register index of the configuration port
	localparam logic REG_APP_CURSOR = 1'b0;

	// sequence descriptor: bytes in order from seq[0], len counts them (0 = nothing)
	typedef struct packed {
		byte_t [SEQ_MAX-1:0] seq;
		len_t                len;
	} desc_t;

	typedef struct packed {
		logic twin;  // number has two digits
		byte_t tens;
		byte_t ones;
	} tilde_num_t;

	function automatic byte_t cursor_letter(key_t key);
		byte_t letter;
		case (key)
			KEY_UP:    letter = 8'h41;
			KEY_DOWN:  letter = 8'h42;
			KEY_RIGHT: letter = 8'h43;
			KEY_LEFT:  letter = 8'h44;
			KEY_HOME:  letter = 8'h48;
			KEY_END:   letter = 8'h46;
			default:   letter = 8'h41;
		endcase
		return letter;
	endfunction

	function automatic tilde_num_t tilde_num(key_t key);
		tilde_num_t n;
		n.twin = 1'b1;
		n.tens = 8'h31;
		case (key)
			KEY_INS:  begin n.twin = 1'b0; n.ones = 8'h32; end
			KEY_DEL:  begin n.twin = 1'b0; n.ones = 8'h33; end
			KEY_PGUP: begin n.twin = 1'b0; n.ones = 8'h35; end
			KEY_PGDN: begin n.twin = 1'b0; n.ones = 8'h36; end
			KEY_F5:   n.ones = 8'h35;
			KEY_F6:   n.ones = 8'h37;
			KEY_F7:   n.ones = 8'h38;
			KEY_F8:   n.ones = 8'h39;
			KEY_F9:   begin n.tens = 8'h32; n.ones = 8'h30; end
			KEY_F10:  begin n.tens = 8'h32; n.ones = 8'h31; end
			KEY_F11:  begin n.tens = 8'h32; n.ones = 8'h33; end
			KEY_F12:  begin n.tens = 8'h32; n.ones = 8'h34; end
			default:  begin n.twin = 1'b0; n.ones = 8'h30; end
		endcase
		return n;
	endfunction

endpackage

// ===== design/tkse_ifs.sv =====
interface tkse_key_if import tkse_pkg::*; ();
	logic  valid;
	logic  ready;
	key_t  key_code;
	logic  shift_held;
	logic  alt_held;
	logic  ctrl_held;

	modport source (output valid, key_code, shift_held, alt_held, ctrl_held, input ready);
	modport sink   (input valid, key_code, shift_held, alt_held, ctrl_held, output ready);
endinterface

interface tkse_byte_if import tkse_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  last_byte;

	modport source (output valid, out_byte, last_byte, input ready);
	modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== design/terminal_key_sequence_encoder.sv =====
// Key event in, terminal byte stream out. Each accepted key is turned into its
// escape sequence by the front classifier in the same cycle and parked in a small
// sequence queue (QUEUE_DEPTH entries); the back serializer sends one byte per
// cycle while byte_out is ready, from a registered output, flagging the final
// byte with last_byte. A key's sequence has 1 to 7 bytes, so the sustained rate
// is set by the serializer at one byte per cycle; keys are accepted every cycle
// while the queue has room. The first byte passes through the queue entry and
// then the output register before it is presented on byte_out. Keys that produce
// nothing (code 0, codes 27..31) are absorbed silently.
// The app_cursor_mode register sits at byte address 0 of the APB port; write it
// only while the block is idle.
module terminal_key_sequence_encoder import tkse_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	tkse_key_if.sink    key_in,
	tkse_byte_if.source byte_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic  app_cursor_q;
	logic  push;
	logic  push_ready;
	desc_t push_desc;
	logic  pop;
	desc_t head;
	logic  head_valid;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_APP_CURSOR) ? {31'd0, app_cursor_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			app_cursor_q <= 1'b0;
		else if (psel && penable && pwrite && paddr[2] == REG_APP_CURSOR)
			app_cursor_q <= pwdata[0];
	end

	tkse_front u_front (
		.key_in     (key_in),
		.app_cursor (app_cursor_q),
		.push       (push),
		.push_desc  (push_desc),
		.push_ready (push_ready)
	);

	tkse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.push_ready (push_ready),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	tkse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.byte_out   (byte_out)
	);

endmodule

// ===== design/tkse_front.sv =====
module tkse_front import tkse_pkg::*; (
	tkse_key_if.sink key_in,
	input  logic     app_cursor,
	output logic     push,
	output desc_t    push_desc,
	input  logic     push_ready
);

	logic       any_mod;
	byte_t      pdig;
	tilde_num_t num;
	key_t       key;

	assign key = key_in.key_code;
	assign key_in.ready = push_ready;

	always_comb begin
		any_mod = key_in.shift_held | key_in.alt_held | key_in.ctrl_held;
		pdig = CH_ONE + {5'd0, key_in.ctrl_held, key_in.alt_held, key_in.shift_held};
		num = tilde_num(key);
		push_desc.seq = '0;
		push_desc.len = '0;

		if (key == KEY_ENTER || key == KEY_BKSP) begin
			if (key_in.alt_held) begin
				push_desc.seq[0] = CH_ESC;
				push_desc.seq[1] = (key == KEY_ENTER) ? CH_CR : CH_DEL;
				push_desc.len = 3'd2;
			end else begin
				push_desc.seq[0] = (key == KEY_ENTER) ? CH_CR : CH_DEL;
				push_desc.len = 3'd1;
			end
		end else if (key == KEY_TAB) begin
			if (key_in.shift_held) begin
				push_desc.seq[0] = CH_ESC;
				push_desc.seq[1] = CH_LBRK;
				push_desc.seq[2] = CH_Z;
				push_desc.len = 3'd3;
			end else begin
				push_desc.seq[0] = CH_HT;
				push_desc.len = 3'd1;
			end
		end else if (key == KEY_ESC) begin
			push_desc.seq[0] = CH_ESC;
			push_desc.len = 3'd1;
		end else if ((key >= KEY_UP && key <= KEY_END) || (key >= KEY_F1 && key <= KEY_F4)) begin
			push_desc.seq[0] = CH_ESC;
			if (any_mod) begin
				push_desc.seq[1] = CH_LBRK;
				push_desc.seq[2] = CH_ONE;
				push_desc.seq[3] = CH_SEMI;
				push_desc.seq[4] = pdig;
				push_desc.len = 3'd6;
			end else begin
				// F1..F4 always take SS3; cursor keys only in application mode
				push_desc.seq[1] = (key >= KEY_F1 || app_cursor) ? CH_O : CH_LBRK;
				push_desc.len = 3'd3;
			end
			if (key >= KEY_F1)
				push_desc.seq[any_mod ? 5 : 2] = CH_P + {3'd0, key - KEY_F1};
			else
				push_desc.seq[any_mod ? 5 : 2] = cursor_letter(key);
		end else if ((key >= KEY_INS && key <= KEY_PGDN) || (key >= KEY_F5 && key <= KEY_F12)) begin
			push_desc.seq[0] = CH_ESC;
			push_desc.seq[1] = CH_LBRK;
			if (num.twin) begin
				push_desc.seq[2] = num.tens;
				push_desc.seq[3] = num.ones;
				if (any_mod) begin
					push_desc.seq[4] = CH_SEMI;
					push_desc.seq[5] = pdig;
					push_desc.seq[6] = CH_TILDE;
					push_desc.len = 3'd7;
				end else begin
					push_desc.seq[4] = CH_TILDE;
					push_desc.len = 3'd5;
				end
			end else begin
				push_desc.seq[2] = num.ones;
				if (any_mod) begin
					push_desc.seq[3] = CH_SEMI;
					push_desc.seq[4] = pdig;
					push_desc.seq[5] = CH_TILDE;
					push_desc.len = 3'd6;
				end else begin
					push_desc.seq[3] = CH_TILDE;
					push_desc.len = 3'd4;
				end
			end
		end
	end

	// drop keys that produce nothing
	assign push = key_in.valid && push_ready && (push_desc.len != '0);

endmodule

// ===== design/tkse_queue.sv =====
module tkse_queue import tkse_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  push_ready,
	input  logic  pop,
	output desc_t head,
	output logic  head_valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t           mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign push_ready = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_desc;
	end

endmodule

// ===== design/tkse_back.sv =====
module tkse_back import tkse_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  desc_t head,
	input  logic  head_valid,
	output logic  pop,
	tkse_byte_if.source byte_out
);

	logic  [LEN_W-1:0] idx_q;
	logic              out_valid_q;
	byte_t             out_byte_q;
	logic              out_last_q;
	logic              load;
	logic              is_last;

	assign load    = head_valid && (!out_valid_q || byte_out.ready);
	assign is_last = (idx_q == head.len - 1'b1);
	assign pop     = load && is_last;

	assign byte_out.valid     = out_valid_q;
	assign byte_out.out_byte  = out_byte_q;
	assign byte_out.last_byte = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			if (load)
				out_valid_q <= 1'b1;
			else if (byte_out.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.seq[idx_q];
			out_last_q <= is_last;
		end
	end

endmodule
